[design/hrpd_pkg.sv]
`default_nettype none
package hrpd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR     = 2'd2;

    // register widths and reset values
    localparam int BATCH_LEN_W = 7;
    localparam int THR_W       = 10;
    localparam int NUM_W       = 16;
    localparam int POS_W       = 6;
    localparam logic [BATCH_LEN_W-1:0] BATCH_LEN_RST = 7'd50;
    localparam logic [THR_W-1:0]       THR_RST       = 10'd900;
    localparam logic [NUM_W-1:0]       NUM_RST       = 16'd3000;

    // result fields
    localparam int FRAC_BITS  = 4;
    localparam int HR_W       = 19;
    localparam int INTERVAL_W = 16;
    localparam int DIVIDEND_W = NUM_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int M_TDATA_W  = ((HR_W + INTERVAL_W + 7) / 8) * 8;

    // job queue, power-of-two depth
    localparam int FIFO_DEPTH = 2;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int DISTANCE_BITS_DEF = 16;

endpackage
`default_nettype wire

[design/heart_rate_peak_detector_unit.sv]
`default_nettype none
// channel  | ports                          | payload (lowest bit first)
// ---------+--------------------------------+------------------------------------
// samples  | s_axis_tvalid/tready/tdata     | sample, zero padded to bytes
// results  | m_axis_tvalid/tready/tdata     | heart_rate[18:0], interval[34:19]
// config   | i_cfg_valid/o_cfg_ready        | i_cfg_index, i_cfg_data
//
// Samples are judged combinationally; the front takes one per cycle while the
// two-entry job queue has room. Each peak after the first is divided in the
// back: a load from the queue, 20 restoring divide steps, then an output load.
// Reset is synchronous and clears the control state; config registers return to
// 50 / 900 / 3000. The output register holds a result while m_axis_tready is low,
// and the divider waits in its done state; the front stalls only on a full queue.
module heart_rate_peak_detector_unit #(
    parameter int SAMPLE_BITS   = hrpd_pkg::SAMPLE_BITS_DEF,
    parameter int DISTANCE_BITS = hrpd_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hrpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hrpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // heart_rate, interval
    output logic [hrpd_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int JOB_W = hrpd_pkg::NUM_W + DISTANCE_BITS;

    logic              fifo_full;
    logic              fifo_push;
    logic              fifo_pop;
    logic              fifo_not_empty;
    logic [JOB_W-1:0]  push_job;
    logic [JOB_W-1:0]  pop_job;
    logic [hrpd_pkg::HR_W-1:0]       heart_rate;
    logic [hrpd_pkg::INTERVAL_W-1:0] interval;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = hrpd_pkg::M_TDATA_W'({interval, heart_rate});

    hrpd_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_full      (fifo_full),
        .o_push      (fifo_push),
        .o_job       (push_job)
    );

    hrpd_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fifo_push),
        .i_data      (push_job),
        .o_full      (fifo_full),
        .i_pop       (fifo_pop),
        .o_not_empty (fifo_not_empty),
        .o_data      (pop_job)
    );

    hrpd_div #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_not_empty  (fifo_not_empty),
        .i_job        (pop_job),
        .o_pop        (fifo_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_heart_rate (heart_rate),
        .o_interval   (interval)
    );

endmodule
`default_nettype wire

[design/hrpd_front.sv]
`default_nettype none
module hrpd_front #(
    parameter int SAMPLE_BITS   = hrpd_pkg::SAMPLE_BITS_DEF,
    parameter int DISTANCE_BITS = hrpd_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [hrpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hrpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [SAMPLE_BITS-1:0]           i_sample,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output logic [hrpd_pkg::NUM_W+DISTANCE_BITS-1:0] o_job
);

    localparam int CMP_W = (SAMPLE_BITS > hrpd_pkg::THR_W) ? SAMPLE_BITS : hrpd_pkg::THR_W;
    localparam logic [DISTANCE_BITS-1:0] DIST_MAX = {DISTANCE_BITS{1'b1}};

    logic [hrpd_pkg::BATCH_LEN_W-1:0] r_batch_len;
    logic [hrpd_pkg::THR_W-1:0]       r_thr;
    logic [hrpd_pkg::NUM_W-1:0]       r_num;

    logic [SAMPLE_BITS-1:0]        r_older, n_older;
    logic [SAMPLE_BITS-1:0]        r_cand;
    logic                          r_cand_valid;
    logic [hrpd_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [DISTANCE_BITS-1:0]      r_dist, n_dist;
    logic                          r_first_seen, n_first_seen;

    logic accept;
    logic last;
    logic peak;
    logic [DISTANCE_BITS-1:0] job_dist;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_len <= hrpd_pkg::BATCH_LEN_RST;
            r_thr       <= hrpd_pkg::THR_RST;
            r_num       <= hrpd_pkg::NUM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hrpd_pkg::CFG_BATCH_LENGTH:
                    r_batch_len <= i_cfg_data[hrpd_pkg::BATCH_LEN_W-1:0];
                hrpd_pkg::CFG_BOUNDARY_THRESHOLD:
                    r_thr <= i_cfg_data[hrpd_pkg::THR_W-1:0];
                hrpd_pkg::CFG_RATE_NUMERATOR:
                    r_num <= i_cfg_data[hrpd_pkg::NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        last = ({1'b0, r_pos} + hrpd_pkg::BATCH_LEN_W'(1)) == r_batch_len;
        peak = r_cand_valid && (r_cand > r_older) && (r_cand >= i_sample)
               && (!last || (CMP_W'(r_cand) > CMP_W'(r_thr)));

        n_older      = r_older;
        n_pos        = r_pos;
        n_dist       = r_dist;
        n_first_seen = r_first_seen;
        if (r_cand_valid) begin
            n_older = r_cand;
            n_pos   = last ? '0 : r_pos + hrpd_pkg::POS_W'(1);
            if (peak) begin
                // restart the count at this peak, then advance once
                n_dist       = DISTANCE_BITS'(1);
                n_first_seen = 1'b1;
            end else if (r_dist != DIST_MAX) begin
                n_dist = r_dist + DISTANCE_BITS'(1);
            end
        end

        job_dist = (r_dist == '0) ? DISTANCE_BITS'(1) : r_dist;
        o_push   = accept && peak && r_first_seen;
        o_job    = {r_num, job_dist};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older      <= '0;
            r_cand       <= '0;
            r_cand_valid <= 1'b0;
            r_pos        <= '0;
            r_dist       <= '0;
            r_first_seen <= 1'b0;
        end else if (accept) begin
            r_older      <= n_older;
            r_cand       <= i_sample;
            r_cand_valid <= 1'b1;
            r_pos        <= n_pos;
            r_dist       <= n_dist;
            r_first_seen <= n_first_seen;
        end
    end

    a_push_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_first_seen && r_cand_valid)
        else $error("job pushed before any peak was seen");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("job pushed into a full queue");
    a_dist_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && peak) |=> r_dist == DISTANCE_BITS'(1))
        else $error("distance did not restart after a peak");

endmodule
`default_nettype wire

[design/hrpd_fifo.sv]
`default_nettype none
module hrpd_fifo #(
    parameter int DATA_W = hrpd_pkg::NUM_W + hrpd_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_not_empty,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTR_W = (hrpd_pkg::FIFO_DEPTH > 1) ? $clog2(hrpd_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(hrpd_pkg::FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(hrpd_pkg::FIFO_DEPTH);

    logic [DATA_W-1:0] r_mem [hrpd_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_count;

    assign o_full      = (r_count == DEPTH_C);
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_not_empty))
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count out of range");

endmodule
`default_nettype wire

[design/hrpd_div.sv]
`default_nettype none
module hrpd_div #(
    parameter int DISTANCE_BITS = hrpd_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_not_empty,
    input  wire logic [hrpd_pkg::NUM_W+DISTANCE_BITS-1:0] i_job,
    output logic                                         o_pop,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic [hrpd_pkg::HR_W-1:0]                    o_heart_rate,
    output logic [hrpd_pkg::INTERVAL_W-1:0]              o_interval
);

    localparam int DW = hrpd_pkg::DIVIDEND_W;
    localparam int WIDE_W = (DISTANCE_BITS > hrpd_pkg::INTERVAL_W) ?
                            DISTANCE_BITS : hrpd_pkg::INTERVAL_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [DW-1:0]                  r_dvd, n_dvd;
    logic [DISTANCE_BITS-1:0]       r_div, n_div;
    logic [DISTANCE_BITS-1:0]       r_rem, n_rem;
    logic [hrpd_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_ovalid, n_ovalid;
    logic [hrpd_pkg::HR_W-1:0]      r_hr, n_hr;
    logic [hrpd_pkg::INTERVAL_W-1:0] r_ivl, n_ivl;

    logic [DISTANCE_BITS:0]         shifted;
    logic [DISTANCE_BITS:0]         diff;
    logic                           ge;
    logic [DISTANCE_BITS-1:0]       job_d;
    logic [hrpd_pkg::NUM_W-1:0]     job_num;
    logic [WIDE_W-1:0]              div_wide;

    assign o_valid      = r_ovalid;
    assign o_heart_rate = r_hr;
    assign o_interval   = r_ivl;

    always_comb begin
        job_d    = i_job[DISTANCE_BITS-1:0];
        job_num  = i_job[hrpd_pkg::NUM_W+DISTANCE_BITS-1:DISTANCE_BITS];
        shifted  = {r_rem, r_dvd[DW-1]};
        diff     = shifted - {1'b0, r_div};
        ge       = shifted >= {1'b0, r_div};
        div_wide = WIDE_W'(r_div);

        n_state  = r_state;
        n_dvd    = r_dvd;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_hr     = r_hr;
        n_ivl    = r_ivl;
        n_ovalid = r_ovalid && !i_ready;
        o_pop    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_not_empty) begin
                    o_pop   = 1'b1;
                    n_dvd   = {job_num, {hrpd_pkg::FRAC_BITS{1'b0}}};
                    n_div   = (job_d == '0) ? DISTANCE_BITS'(1) : job_d;
                    n_rem   = '0;
                    n_cnt   = hrpd_pkg::DIV_CNT_W'(DW - 1);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // one restoring step; quotient bits shift in from the bottom
                n_rem = ge ? diff[DISTANCE_BITS-1:0] : shifted[DISTANCE_BITS-1:0];
                n_dvd = {r_dvd[DW-2:0], ge};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - hrpd_pkg::DIV_CNT_W'(1);
                end
            end
            ST_DONE: begin
                // hold the quotient until the output slot frees up
                if (!r_ovalid || i_ready) begin
                    n_hr     = r_dvd[hrpd_pkg::HR_W-1:0];
                    n_ivl    = div_wide[hrpd_pkg::INTERVAL_W-1:0];
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_hr  <= n_hr;
        r_ivl <= n_ivl;
    end

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> r_div != '0)
        else $error("division by zero in progress");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> r_rem < r_div)
        else $error("partial remainder not below divisor");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ovalid && !(r_ovalid && !i_ready)) |-> r_state == ST_DONE)
        else $error("result loaded outside the done state");

endmodule
`default_nettype wire

[tb/heart_rate_peak_detector_checker.sv]
module heart_rate_peak_detector_checker
    import hrpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [((SAMPLE_BITS_DEF+7)/8)*8-1:0] i_s_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [M_TDATA_W-1:0]  i_m_tdata,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W  = SAMPLE_BITS_DEF;
    localparam int DIST_W = DISTANCE_BITS_DEF;

    // interval sits above heart_rate on the result bus
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [HR_W-1:0]       rate;
    } t_beat;

    logic [BATCH_LEN_W-1:0] batch_len;
    logic [THR_W-1:0]       edge_thr;
    logic [NUM_W-1:0]       rate_num;

    logic [SMP_W-1:0]  prev_smp;
    logic [SMP_W-1:0]  cand_smp;
    logic              cand_ok;
    logic [POS_W-1:0]  pos;
    logic [DIST_W-1:0] gap_cnt;
    logic              seen_peak;

    t_beat beat_q[$];
    int    mismatches = 0;

    // judge the waiting candidate against the new sample, queue the beat it yields
    task automatic judge_sample(input logic [SMP_W-1:0] x);
        logic              at_end;
        logic              is_peak;
        logic [DIST_W-1:0] d;
        logic [63:0]       quot;
        t_beat             b;
        if (cand_ok) begin
            at_end  = (32'(pos) + 1 == 32'(batch_len));
            is_peak = (cand_smp > prev_smp) && (cand_smp >= x)
                      && (!at_end || cand_smp > edge_thr);
            if (is_peak) begin
                if (seen_peak) begin
                    d          = (gap_cnt == '0) ? DIST_W'(1) : gap_cnt;
                    quot       = (64'(rate_num) << FRAC_BITS) / 64'(d);
                    b.rate     = quot[HR_W-1:0];
                    b.interval = d[INTERVAL_W-1:0];
                    beat_q.push_back(b);
                end
                seen_peak = 1'b1;
                gap_cnt   = '0;
            end
            if (gap_cnt != '1)
                gap_cnt = gap_cnt + 1'b1;
            pos      = at_end ? '0 : pos + 1'b1;
            prev_smp = cand_smp;
        end
        cand_smp = x;
        cand_ok  = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            batch_len = BATCH_LEN_RST;
            edge_thr  = THR_RST;
            rate_num  = NUM_RST;
            prev_smp  = '0;
            cand_smp  = '0;
            cand_ok   = 1'b0;
            pos       = '0;
            gap_cnt   = '0;
            seen_peak = 1'b0;
            beat_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BATCH_LENGTH:       batch_len = i_cfg_data[BATCH_LEN_W-1:0];
                    CFG_BOUNDARY_THRESHOLD: edge_thr  = i_cfg_data[THR_W-1:0];
                    CFG_RATE_NUMERATOR:     rate_num  = i_cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_beat'(i_m_tdata[HR_W+INTERVAL_W-1:0]);
                if (beat_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got rate %0d interval %0d",
                             $time, got.rate, got.interval);
                end else begin
                    want = beat_q.pop_front();
                    if (got.rate !== want.rate) begin
                        mismatches++;
                        $display("%0t: heart rate mismatch: expected %0d, got %0d",
                                 $time, want.rate, got.rate);
                    end
                    if (got.interval !== want.interval) begin
                        mismatches++;
                        $display("%0t: interval mismatch: expected %0d, got %0d",
                                 $time, want.interval, got.interval);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                judge_sample(i_s_tdata[SMP_W-1:0]);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= beat_q.size();
    end

endmodule

[tb/heart_rate_peak_detector_unit_tb.sv]
module heart_rate_peak_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W        = hrpd_pkg::SAMPLE_BITS_DEF;
    localparam int S_TDATA_W    = ((SMP_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 96;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 19;
    localparam int PHASE_ITEMS  = 125;
    localparam int GAP_SAMPLES  = 80;
    localparam int THR_LOCAL_W  = hrpd_pkg::THR_W;
    localparam logic [hrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_valid   = 1'b0;
    logic [hrpd_pkg::CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [hrpd_pkg::CFG_DATA_W-1:0]    i_cfg_data    = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]               s_axis_tdata  = '0;
    logic                               m_axis_tready = 1'b0;
    logic                               o_cfg_ready;
    logic                               s_axis_tready;
    logic                               m_axis_tvalid;
    logic [hrpd_pkg::M_TDATA_W-1:0]     m_axis_tdata;

    logic steady  = 1'b0;   // no idling on either side
    logic rx_hold = 1'b0;   // ask the receiver for its long hold-off
    int   samples_sent = 0;
    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    logic [THR_LOCAL_W-1:0] cur_thr = hrpd_pkg::THR_RST;

    logic [SMP_W-1:0] opening_run [16] = '{10'd1023, 10'd1023, 10'd0, 10'd0, 10'd512,
        10'd511, 10'd512, 10'd512, 10'd0, 10'd1, 10'd0, 10'd1023, 10'd1022, 10'd700,
        10'd700, 10'd900};
    logic [SMP_W-1:0] edge_run [8] = '{10'd0, 10'd900, 10'd0, 10'd901, 10'd0, 10'd1023,
        10'd1023, 10'd0};

    heart_rate_peak_detector_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    heart_rate_peak_detector_checker hr_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_sample(input logic [SMP_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= S_TDATA_W'(value);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [hrpd_pkg::CFG_IDX_W-1:0] index,
                             input logic [hrpd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid and wait until every beat is out and the divider has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [hrpd_pkg::BATCH_LEN_W-1:0] batch_len,
                               input logic [hrpd_pkg::THR_W-1:0] thr,
                               input logic [hrpd_pkg::NUM_W-1:0] num);
        logic [hrpd_pkg::CFG_DATA_W-1:0] d;
        settle();
        // unused upper bits carry junk half the time
        d = hrpd_pkg::CFG_DATA_W'($urandom);
        if ($urandom_range(1))
            d[hrpd_pkg::CFG_DATA_W-1:hrpd_pkg::BATCH_LEN_W] = '0;
        d[hrpd_pkg::BATCH_LEN_W-1:0] = batch_len;
        write_reg(hrpd_pkg::CFG_BATCH_LENGTH, d);
        d = hrpd_pkg::CFG_DATA_W'($urandom);
        if ($urandom_range(1))
            d[hrpd_pkg::CFG_DATA_W-1:hrpd_pkg::THR_W] = '0;
        d[hrpd_pkg::THR_W-1:0] = thr;
        write_reg(hrpd_pkg::CFG_BOUNDARY_THRESHOLD, d);
        write_reg(hrpd_pkg::CFG_RATE_NUMERATOR, num);
        cur_thr = thr;
    endtask

    // one heartbeat: baseline, rise, peak, fall; sometimes plain noise instead
    task automatic send_beat();
        int kind;
        int len;
        int base;
        int crest;
        int k;
        kind = $urandom_range(99);
        if (kind < 12) begin
            len = $urandom_range(1, 12);
            repeat (len) send_sample(SMP_W'($urandom));
        end else begin
            base = $urandom_range(0, 255);
            len  = $urandom_range(0, 40);
            for (k = 0; k < len; k++)
                send_sample(kind < 40 ? SMP_W'(base + $urandom_range(0, 3)) : SMP_W'(base));
            crest = $urandom_range(base + 1, 1023);
            // aim some crests right at the boundary level
            if (kind % 5 == 0) begin
                crest = int'(cur_thr) + $urandom_range(0, 1);
                if (crest > 1023)
                    crest = 1023;
                if (crest <= base)
                    crest = base + 1;
            end
            len = $urandom_range(1, 4);
            for (k = 1; k <= len; k++)
                send_sample(SMP_W'(base + (crest - base) * k / (len + 1)));
            send_sample(SMP_W'(crest));
            if (kind >= 85)
                send_sample(SMP_W'(crest));
            len = $urandom_range(1, 4);
            for (k = len; k >= 1; k--)
                send_sample(SMP_W'(crest * k / (len + 1)));
        end
    endtask

    task automatic random_phase(input logic [hrpd_pkg::BATCH_LEN_W-1:0] batch_len,
                                input logic [hrpd_pkg::THR_W-1:0] thr,
                                input logic [hrpd_pkg::NUM_W-1:0] num,
                                input logic no_idle,
                                input logic hold);
        int first;
        load_config(batch_len, thr, num);
        steady = no_idle;
        if (hold)
            rx_hold = 1'b1;
        first = samples_sent;
        while (samples_sent - first < PHASE_ITEMS)
            send_beat();
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first sample, flat tops, extremes
        foreach (opening_run[i])
            send_sample(opening_run[i]);

        // every position is a batch end, and a zero numerator
        load_config(7'd1, 10'd900, 16'd0);
        foreach (edge_run[i])
            send_sample(edge_run[i]);

        random_phase(7'd64, 10'd1023, 16'd65535, 1'b0, 1'b0);
        random_phase(7'd1, 10'd0, 16'd1, 1'b1, 1'b0);
        random_phase(7'd0, 10'd300, 16'd3000, 1'b0, 1'b1);
        random_phase(7'd100, 10'd600, 16'd12345, 1'b0, 1'b0);
        random_phase(7'd3, 10'd512, 16'd6000, 1'b0, 1'b0);
        repeat (3)
            random_phase(7'($urandom_range(1, 64)), 10'($urandom_range(0, 1023)),
                         16'($urandom_range(1, 65535)), 1'b0, 1'b0);

        // long flat stretch between two peaks
        load_config(7'd50, 10'd900, 16'd3000);
        write_reg(CFG_SPARE, hrpd_pkg::CFG_DATA_W'($urandom));
        steady = 1'b1;
        send_sample(10'd300);
        send_sample(10'd800);
        send_sample(10'd0);
        repeat (GAP_SAMPLES) send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        steady = 1'b0;

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
